// ===== hw/rtl/aphp_pkg.sv =====
// Package: types, character classifier and transition table of the header parser.
package aphp_pkg;

	typedef enum logic [2:0] {
		CLS_START = 3'd0,
		CLS_DIGIT = 3'd1,
		CLS_LETTER = 3'd2,
		CLS_EQUALS = 3'd3,
		CLS_END = 3'd4,
		CLS_JUNK = 3'd5,
		CLS_SPACE = 3'd6,
		CLS_TIMEOUT = 3'd7
	} class_t;

	typedef enum logic [3:0] {
		ST_LISTEN = 4'd0,
		ST_START = 4'd1,
		ST_FROM = 4'd2,
		ST_END_FROM = 4'd3,
		ST_TO = 4'd4,
		ST_END_TO = 4'd5,
		ST_TALKER = 4'd6,
		ST_END_TALKER = 4'd7,
		ST_TYPE = 4'd8,
		ST_VALUE = 4'd9,
		ST_PAYLOAD = 4'd10
	} state_t;

	typedef enum logic [1:0] {
		NAK_NONE = 2'd0,
		NAK_MAL = 2'd1,
		NAK_TMO = 2'd2
	} nak_kind_t;

	typedef enum logic [2:0] {
		FLD_START = 3'd0,
		FLD_FROM = 3'd1,
		FLD_TO = 3'd2,
		FLD_TALKER = 3'd3,
		FLD_TYPE = 3'd4,
		FLD_VALUE = 3'd5,
		FLD_PAYLOAD = 3'd6
	} field_t;

	localparam logic [6:0] CHAR_MASK = 7'h7F;

	// registered input word
	typedef struct packed {
		logic valid;
		logic tick;
		logic [6:0] ch;
	} in_word_t;

	// one table entry
	typedef struct packed {
		state_t next;
		logic save;
		logic pstart;
		logic pdone;
		nak_kind_t nak;
		field_t field;
	} act_t;

	// full result word
	typedef struct packed {
		class_t cls;
		act_t act;
		logic [6:0] ch;
	} res_t;

	function automatic class_t classify(input logic [6:0] c);
		class_t r;
		if (c == 7'h01 || c == 7'h21)
			r = CLS_START;
		else if (c >= 7'h30 && c <= 7'h39)
			r = CLS_DIGIT;
		else if ((c >= 7'h41 && c <= 7'h5A) || (c >= 7'h61 && c <= 7'h7A))
			r = CLS_LETTER;
		else if (c == 7'h3D)
			r = CLS_EQUALS;
		else if (c == 7'h00 || c == 7'h0A || c == 7'h0D || c == 7'h3B)
			r = CLS_END;
		else if (c == 7'h09 || c == 7'h20)
			r = CLS_SPACE;
		else
			r = CLS_JUNK;
		return r;
	endfunction

	function automatic act_t go(input state_t s, input logic save);
		act_t a;
		a = '{next: s, save: save, pstart: 1'b0, pdone: 1'b0, nak: NAK_NONE, field: FLD_START};
		return a;
	endfunction

	function automatic act_t mal(input field_t f);
		act_t a;
		a = '{next: ST_LISTEN, save: 1'b0, pstart: 1'b0, pdone: 1'b0, nak: NAK_MAL, field: f};
		return a;
	endfunction

	function automatic act_t tmo(input field_t f);
		act_t a;
		a = '{next: ST_LISTEN, save: 1'b0, pstart: 1'b0, pdone: 1'b0, nak: NAK_TMO, field: f};
		return a;
	endfunction

	function automatic act_t restart();
		act_t a;
		a = go(ST_START, 1'b0);
		a.pstart = 1'b1;
		return a;
	endfunction

	function automatic act_t row_delim(input state_t dig, input state_t spc, input field_t f,
			input field_t tf, input class_t c);
		act_t a;
		case (c)
			CLS_START: a = restart();
			CLS_DIGIT: a = go(dig, 1'b1);
			CLS_SPACE: a = go(spc, 1'b0);
			CLS_TIMEOUT: a = tmo(tf);
			default: a = mal(f);
		endcase
		return a;
	endfunction

	function automatic act_t lookup(input state_t s, input class_t c);
		act_t a;
		case (s)
			ST_START: begin
				case (c)
					CLS_START: a = restart();
					CLS_DIGIT: a = go(ST_FROM, 1'b1);
					CLS_LETTER: a = go(ST_TYPE, 1'b1);
					CLS_SPACE: a = go(ST_START, 1'b0);
					CLS_TIMEOUT: a = tmo(FLD_START);
					default: a = mal(FLD_START);
				endcase
			end
			ST_FROM: a = row_delim(ST_FROM, ST_END_FROM, FLD_FROM, FLD_FROM, c);
			ST_END_FROM: a = row_delim(ST_TO, ST_END_FROM, FLD_TO, FLD_TO, c);
			ST_TO: a = row_delim(ST_TO, ST_END_TO, FLD_TO, FLD_TO, c);
			ST_END_TO: begin
				if (c == CLS_LETTER)
					a = go(ST_TYPE, 1'b1);
				else
					a = row_delim(ST_TALKER, ST_END_TO, FLD_TALKER, FLD_TO, c);
			end
			ST_TALKER: a = row_delim(ST_TALKER, ST_END_TALKER, FLD_TALKER, FLD_TALKER, c);
			ST_END_TALKER: begin
				case (c)
					CLS_START: a = restart();
					CLS_LETTER: a = go(ST_TYPE, 1'b1);
					CLS_SPACE: a = go(ST_END_TALKER, 1'b0);
					CLS_TIMEOUT: a = tmo(FLD_TYPE);
					default: a = mal(FLD_TYPE);
				endcase
			end
			ST_TYPE: begin
				case (c)
					CLS_START: a = restart();
					CLS_LETTER: a = go(ST_TYPE, 1'b1);
					CLS_EQUALS: a = go(ST_VALUE, 1'b0);
					CLS_SPACE: a = go(ST_VALUE, 1'b0);
					CLS_TIMEOUT: a = tmo(FLD_TYPE);
					default: a = mal(FLD_TYPE);
				endcase
			end
			ST_VALUE: begin
				case (c)
					CLS_START: a = restart();
					CLS_DIGIT: a = go(ST_VALUE, 1'b1);
					CLS_LETTER: a = go(ST_VALUE, 1'b1);
					CLS_SPACE: a = go(ST_PAYLOAD, 1'b0);
					CLS_TIMEOUT: a = tmo(FLD_VALUE);
					default: a = mal(FLD_VALUE);
				endcase
			end
			ST_PAYLOAD: begin
				case (c)
					CLS_END: begin
						a = go(ST_LISTEN, 1'b0);
						a.pdone = 1'b1;
					end
					CLS_TIMEOUT: a = tmo(FLD_PAYLOAD);
					default: a = go(ST_PAYLOAD, 1'b1);
				endcase
			end
			default: begin
				// listen, and any undecodable state
				if (c == CLS_START)
					a = restart();
				else
					a = go(ST_LISTEN, 1'b0);
			end
		endcase
		return a;
	endfunction

endpackage

// ===== hw/rtl/aphp_if.sv =====
// Valid/ready channel interfaces for parser input words and result words.
interface aphp_in_if;
	logic valid;
	logic ready;
	logic command;
	logic [7:0] in_char;
	modport source(output valid, command, in_char, input ready);
	modport sink(input valid, command, in_char, output ready);
endinterface

interface aphp_out_if;
	logic valid;
	logic ready;
	logic [2:0] char_class;
	logic [3:0] parser_state;
	logic save_char;
	logic [6:0] saved_char;
	logic packet_start;
	logic packet_done;
	logic [1:0] nak_kind;
	logic [2:0] nak_field;
	modport source(output valid, char_class, parser_state, save_char, saved_char,
		packet_start, packet_done, nak_kind, nak_field, input ready);
	modport sink(input valid, char_class, parser_state, save_char, saved_char,
		packet_start, packet_done, nak_kind, nak_field, output ready);
endinterface

// ===== hw/rtl/aphp_in_stage.sv =====
// Input register: captures the masked character or timeout tick of each word.
module aphp_in_stage (
	input logic clk,
	input logic arst_n,
	aphp_in_if.sink chars,
	input logic take,
	output aphp_pkg::in_word_t word
);
	logic valid_s1;
	logic tick_s1;
	logic [6:0] ch_s1;
	logic load;

	assign chars.ready = !valid_s1 || take;
	assign load = chars.valid && chars.ready;
	assign word = '{valid: valid_s1, tick: tick_s1, ch: ch_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load || (valid_s1 && !take);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tick_s1 <= chars.command;
			ch_s1 <= chars.command ? 7'd0 : (chars.in_char[6:0] & aphp_pkg::CHAR_MASK);
		end
	end
endmodule

// ===== hw/rtl/aphp_fsm.sv =====
// Parser state register with classification and transition table lookup.
module aphp_fsm (
	input logic clk,
	input logic arst_n,
	input aphp_pkg::in_word_t word,
	input logic take,
	output aphp_pkg::res_t res
);
	aphp_pkg::state_t state_q;
	aphp_pkg::class_t cls;
	aphp_pkg::act_t act;

	always_comb begin
		cls = word.tick ? aphp_pkg::CLS_TIMEOUT : aphp_pkg::classify(word.ch);
		act = aphp_pkg::lookup(state_q, cls);
		res = '{cls: cls, act: act, ch: word.ch};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aphp_pkg::ST_LISTEN;
		end else if (take) begin
			state_q <= act.next;
		end
	end
endmodule

// ===== hw/rtl/aphp_out_reg.sv =====
// Result register driving the output channel.
module aphp_out_reg (
	input logic clk,
	input logic arst_n,
	input logic take,
	input aphp_pkg::res_t res,
	output logic free,
	aphp_out_if.source results
);
	logic valid_q;
	aphp_pkg::res_t res_q;

	assign free = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

	assign results.valid = valid_q;
	assign results.char_class = res_q.cls;
	assign results.parser_state = res_q.act.next;
	assign results.save_char = res_q.act.save;
	assign results.saved_char = res_q.ch;
	assign results.packet_start = res_q.act.pstart;
	assign results.packet_done = res_q.act.pdone;
	assign results.nak_kind = res_q.act.nak;
	assign results.nak_field = res_q.act.field;
endmodule

// ===== hw/rtl/ascii_packet_header_parser_core.sv =====
// Top level of the ASCII packet header parser.
// One word (a character or a receive-timeout tick) is accepted every cycle unless the result
// side stalls, and yields one result word: the word is held in the input register and its
// result in the result register. The rate is set by the parser state register, updated for
// each taken word through the 7-bit classifier and the 11-state transition table. A stalled
// result side holds one result in the result register and one word in the input register.
module ascii_packet_header_parser_core (
	input logic clk,
	input logic arst_n,
	aphp_in_if.sink chars,
	aphp_out_if.source results
);
	aphp_pkg::in_word_t word;
	aphp_pkg::res_t res;
	logic free;
	logic take;

	assign take = word.valid && free;

	aphp_in_stage u_in (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars),
		.take(take),
		.word(word)
	);

	aphp_fsm u_fsm (
		.clk(clk),
		.arst_n(arst_n),
		.word(word),
		.take(take),
		.res(res)
	);

	aphp_out_reg u_out (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.res(res),
		.free(free),
		.results(results)
	);
endmodule

// ===== hw/rtl/aphp_checker.sv =====
// Port-level checks on parser results, bound to the top level.
module aphp_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] char_class,
	input logic [3:0] parser_state,
	input logic save_char,
	input logic [6:0] saved_char,
	input logic packet_start,
	input logic packet_done,
	input logic [1:0] nak_kind,
	input logic [2:0] nak_field
);
	// a NAK or packet completion always drops back to listen
	a_back_to_listen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (nak_kind != aphp_pkg::NAK_NONE || packet_done)
		|-> parser_state == aphp_pkg::ST_LISTEN)
		else $error("parser not in listen after NAK or packet done");

	a_field_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && nak_kind == aphp_pkg::NAK_NONE |-> nak_field == 3'd0)
		else $error("nak_field set without NAK");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && packet_start
		|-> parser_state == aphp_pkg::ST_START && char_class == aphp_pkg::CLS_START)
		else $error("packet_start without start character");

	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_class == aphp_pkg::CLS_TIMEOUT
		|-> !save_char && saved_char == 7'd0 && !packet_start && !packet_done)
		else $error("timeout result carries character data");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(parser_state) && $stable(char_class)
		&& $stable(saved_char) && $stable(nak_kind))
		else $error("stalled result changed");
endmodule

bind ascii_packet_header_parser_core aphp_checker u_aphp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.char_class(results.char_class),
	.parser_state(results.parser_state),
	.save_char(results.save_char),
	.saved_char(results.saved_char),
	.packet_start(results.packet_start),
	.packet_done(results.packet_done),
	.nak_kind(results.nak_kind),
	.nak_field(results.nak_field)
);
